### rtl/core/iaws_pkg.sv
// ----------------------------------------------------------------------------
// iaws_pkg
// Types and constants shared by the fixed-capacity vector cells and control.
// ----------------------------------------------------------------------------
`default_nettype none

package iaws_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_READ   = 3'd4,
    KIND_WRITE  = 3'd5,
    KIND_CLEAR  = 3'd6
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_LOAD     = 2'd1,
    CELL_INSERT   = 2'd2,
    CELL_SHIFT_DN = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SHIFT = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [WIDTH-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/indexed_array_with_shift.sv
// Path: a command passes the command register, then the result register.
// Throughput: one command per cycle unless the output stalls; an erase of a
//   run r > 1 stalls new commands while cells shift down one slot per cycle.
// Reset: clears the element count and all valid flags; stored words are
//   undefined until written.
// ----------------------------------------------------------------------------
// indexed_array_with_shift
// Fixed-capacity vector built as a chain of shifting storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_array_with_shift (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_kind,
  input  wire  [4:0]  in_position,
  input  wire  [4:0]  in_run_length,
  input  wire  [31:0] in_value,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_read_data,
  output logic [4:0]  out_count_now,
  output logic [1:0]  out_status
);
  import iaws_pkg::*;

  cell_ctrl_t       cell_ctrl;
  logic [WIDTH-1:0] cell_q [DEPTH];
  logic [IDX_W-1:0] rd_pos;
  logic [WIDTH-1:0] rd_word;

  assign rd_word = cell_q[rd_pos];

  iaws_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_run_length (in_run_length),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_count_now (out_count_now),
    .out_status    (out_status),
    .cell_ctrl     (cell_ctrl),
    .rd_pos        (rd_pos),
    .rd_word       (rd_word)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end
    iaws_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .left_q  (left_w),
      .right_q (right_w),
      .q       (cell_q[i])
    );
  end

endmodule

`default_nettype wire

### rtl/core/iaws_cell.sv
// ----------------------------------------------------------------------------
// iaws_cell
// One storage slot of the vector chain; loads, holds or takes a neighbor word.
// ----------------------------------------------------------------------------
`default_nettype none

module iaws_cell #(
  parameter int IDX = 0
) (
  input  wire                        clk,
  input  wire iaws_pkg::cell_ctrl_t  ctrl,
  input  wire [iaws_pkg::WIDTH-1:0]  left_q,
  input  wire [iaws_pkg::WIDTH-1:0]  right_q,
  output logic [iaws_pkg::WIDTH-1:0] q
);
  import iaws_pkg::*;

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.op)
      CELL_LOAD: begin
        if (ctrl.pos == IDX_P) q_nxt = ctrl.value;
      end
      CELL_INSERT: begin
        if (ctrl.pos == IDX_P) q_nxt = ctrl.value;
        else if (IDX_P > ctrl.pos) q_nxt = left_q;
      end
      CELL_SHIFT_DN: begin
        if (IDX_P >= ctrl.pos) q_nxt = right_q;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

### rtl/core/iaws_ctrl.sv
// ----------------------------------------------------------------------------
// iaws_ctrl
// Command register, count, status decode, erase sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iaws_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [2:0]                   in_kind,
  input  wire  [iaws_pkg::POS_W-1:0]   in_position,
  input  wire  [iaws_pkg::POS_W-1:0]   in_run_length,
  input  wire  [iaws_pkg::DATA_W-1:0]  in_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [iaws_pkg::DATA_W-1:0]  out_read_data,
  output logic [iaws_pkg::CNT_W-1:0]   out_count_now,
  output logic [1:0]                   out_status,
  output iaws_pkg::cell_ctrl_t         cell_ctrl,
  output logic [iaws_pkg::IDX_W-1:0]   rd_pos,
  input  wire  [iaws_pkg::WIDTH-1:0]   rd_word
);
  import iaws_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  ctrl_state_t       state_r, state_nxt;
  logic              cmd_valid_r, cmd_valid_nxt;
  cmd_kind_t         kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  run_r;
  logic [WIDTH-1:0]  value_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [POS_W-1:0]  shift_pos_r, shift_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  status_t           status_r, status_nxt;
  logic              fire;
  logic              accept;
  logic              erase_long;
  logic [CNT_W:0]    erase_end;

  assign fire     = (state_r == S_IDLE) && cmd_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = cmd_valid_r && !fire;
  assign accept   = in_valid && !in_stall;
  assign rd_pos   = pos_r[IDX_W-1:0];
  assign erase_end = {1'b0, pos_r} + {1'b0, run_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire && erase_long) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (remain_r == CNT_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    rdata_nxt      = '0;
    erase_long     = 1'b0;
    cell_ctrl.op   = CELL_HOLD;
    cell_ctrl.pos  = pos_r;
    cell_ctrl.value = value_r;
    remain_nxt     = remain_r;
    shift_pos_nxt  = shift_pos_r;
    case (state_r)
      S_IDLE: begin
        case (kind_r)
          KIND_PUSH: begin
            if (count_r >= DEPTH_C) begin
              status_nxt = ST_FULL;
            end else begin
              cell_ctrl.op  = CELL_LOAD;
              cell_ctrl.pos = POS_W'(count_r);
              count_nxt     = count_r + CNT_W'(1);
            end
          end
          KIND_POP: begin
            if (count_r == '0) status_nxt = ST_EMPTY;
            else count_nxt = count_r - CNT_W'(1);
          end
          KIND_INSERT: begin
            if (count_r >= DEPTH_C) begin
              status_nxt = ST_FULL;
            end else if (pos_r > POS_W'(count_r)) begin
              status_nxt = ST_RANGE;
            end else begin
              cell_ctrl.op = CELL_INSERT;
              count_nxt    = count_r + CNT_W'(1);
            end
          end
          KIND_ERASE: begin
            if (erase_end > {1'b0, count_r}) begin
              status_nxt = ST_RANGE;
            end else begin
              count_nxt = count_r - CNT_W'(run_r);
              if (run_r != '0) cell_ctrl.op = CELL_SHIFT_DN;
              erase_long    = (run_r > POS_W'(1));
              remain_nxt    = CNT_W'(run_r) - CNT_W'(1);
              shift_pos_nxt = pos_r;
            end
          end
          KIND_READ: begin
            if (pos_r >= POS_W'(count_r)) status_nxt = ST_RANGE;
            else rdata_nxt = DATA_W'(signed'(rd_word));
          end
          KIND_WRITE: begin
            if (pos_r >= POS_W'(count_r)) status_nxt = ST_RANGE;
            else cell_ctrl.op = CELL_LOAD;
          end
          KIND_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
        if (!fire) begin
          cell_ctrl.op = CELL_HOLD;
          count_nxt    = count_r;
        end
      end
      S_SHIFT: begin
        cell_ctrl.op  = CELL_SHIFT_DN;
        cell_ctrl.pos = shift_pos_r;
        remain_nxt    = remain_r - CNT_W'(1);
      end
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (fire) cmd_valid_nxt = 1'b0;
    if (accept) cmd_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_valid_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cmd_valid_r <= cmd_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= cmd_kind_t'(in_kind);
      pos_r   <= in_position;
      run_r   <= in_run_length;
      value_r <= in_value[WIDTH-1:0];
    end
    if (fire) begin
      rdata_r     <= rdata_nxt;
      status_r    <= status_nxt;
      shift_pos_r <= shift_pos_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rdata_r;
  assign out_count_now = count_r;
  assign out_status    = status_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count exceeds capacity");

  a_shift_remain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> remain_r != '0)
    else $error("erase sequencer running with nothing left to shift");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed command produced no result");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status_nxt != ST_OK |=> count_r == $past(count_r))
    else $error("failed command changed the count");

  a_no_fire_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> !fire && !out_valid_nxt || !fire)
    else $error("command executed during erase shift");
`endif

endmodule

`default_nettype wire

### bench/indexed_array_with_shift_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_array_with_shift_tb
// Drives push, pop, insert, erase, read, write and clear commands into the
// fixed-capacity vector. The bench starts with a short table of edge cases
// and then sends random traffic biased by the current fill level. Sender
// bursts and receiver stalls are random, and one long receiver hold-off
// backs the block up. Each response is checked against the table's reply
// if given, else a shadow copy of the vector contents and element count.
// ----------------------------------------------------------------------------

module indexed_array_with_shift_tb;
  import iaws_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  pos;
    logic [4:0]  run;
    logic [31:0] value;
  } vec_cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [4:0]  count;
    status_t     status;
  } vec_reply_t;

  typedef struct packed {
    vec_cmd_t   cmd;
    logic       typed;
    vec_reply_t reply;
  } plan_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [4:0]  in_position = '0;
  logic [4:0]  in_run_length = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic [4:0]  out_count_now;
  logic [1:0]  out_status;

  logic [31:0] vec_mem [DEPTH];
  int          vec_count = 0;
  int          max_fill = 0;

  plan_step_t  plan_q[$];
  vec_reply_t  due_replies[$];
  plan_step_t  cur_step;
  vec_reply_t  reply;
  vec_reply_t  want;

  int n_total = 0;
  int n_directed = 0;
  int n_issued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int err_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  bit cmds_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_array_with_shift u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_run_length (in_run_length),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_count_now (out_count_now),
    .out_status    (out_status)
  );

  function automatic vec_reply_t apply_vector_cmd(input vec_cmd_t c);
    vec_reply_t r;
    int n;
    int p;
    int rl;
    int i;
    n = vec_count;
    p = c.pos;
    rl = c.run;
    r.read_data = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_PUSH: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          vec_mem[n] = c.value;
          vec_count = n + 1;
        end
      end
      KIND_POP: begin
        if (n == 0) r.status = ST_EMPTY;
        else vec_count = n - 1;
      end
      KIND_INSERT: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p > n) begin
          r.status = ST_RANGE;
        end else begin
          for (i = n; i > p; i--) vec_mem[i] = vec_mem[i-1];
          vec_mem[p] = c.value;
          vec_count = n + 1;
        end
      end
      KIND_ERASE: begin
        if (p + rl > n) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + rl < n; i++) vec_mem[i] = vec_mem[i+rl];
          vec_count = n - rl;
        end
      end
      KIND_READ: begin
        if (p >= n) r.status = ST_RANGE;
        else r.read_data = vec_mem[p];
      end
      KIND_WRITE: begin
        if (p >= n) r.status = ST_RANGE;
        else vec_mem[p] = c.value;
      end
      KIND_CLEAR: begin
        vec_count = 0;
      end
      default: begin
      end
    endcase
    r.count = vec_count[4:0];
    return r;
  endfunction

  // Lean toward growth when nearly empty and toward shrinking when nearly full.
  function automatic vec_cmd_t draw_command();
    vec_cmd_t c;
    int n;
    int roll;
    int grow;
    int room;
    n = vec_count;
    roll = $urandom_range(0, 99);
    grow = (n < 6) ? 20 : ((n > 13) ? 6 : 13);
    if (roll < 2) c.kind = KIND_UNUSED;
    else if (roll < 5) c.kind = KIND_CLEAR;
    else if (roll < 5 + grow) c.kind = KIND_PUSH;
    else if (roll < 5 + 2 * grow) c.kind = KIND_INSERT;
    else if (roll < 15 + 2 * grow) c.kind = KIND_POP;
    else if (roll < 27 + 2 * grow) c.kind = KIND_ERASE;
    else if (roll < 86) c.kind = KIND_READ;
    else c.kind = KIND_WRITE;

    if ($urandom_range(0, 9) < 8) c.pos = 5'($urandom_range(0, n));
    else c.pos = 5'($urandom_range(0, 31));

    room = n - int'(c.pos);
    if (room < 0) room = 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) c.run = 5'($urandom_range(0, 3));
    else if (roll < 8) c.run = 5'($urandom_range(0, room));
    else c.run = 5'($urandom_range(0, 31));

    case ($urandom_range(0, 13))
      0: c.value = 32'h0000_0000;
      1: c.value = 32'h7FFF_FFFF;
      2: c.value = 32'h8000_0000;
      3: c.value = 32'hFFFF_FFFF;
      default: c.value = $urandom;
    endcase
    return c;
  endfunction

  task automatic add_row(input logic [2:0] k, input int p, input int rl, input logic [31:0] v,
                         input int reps, input bit typed, input logic [31:0] rd,
                         input int cnt, input status_t st);
    plan_step_t s;
    s.cmd.kind = k;
    s.cmd.pos = 5'(p);
    s.cmd.run = 5'(rl);
    s.cmd.value = v;
    s.typed = typed;
    s.reply.read_data = rd;
    s.reply.count = 5'(cnt);
    s.reply.status = st;
    repeat (reps) plan_q = {plan_q, s};
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reply = apply_vector_cmd(cur_step.cmd);
        if (cur_step.typed) reply = cur_step.reply;
        due_replies = {due_replies, reply};
        n_sent++;
        if (vec_count > max_fill) max_fill = vec_count;
        if (n_sent == n_total) cmds_done = 1'b1;
      end
      if (!(in_valid && in_stall)) begin
        if (n_issued == n_total || gap_left > 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          if (plan_q.size() > 0) begin
            cur_step = plan_q.pop_front();
          end else begin
            cur_step.cmd = draw_command();
            cur_step.typed = 1'b0;
            cur_step.reply = '0;
          end
          in_valid <= 1'b1;
          in_kind <= cur_step.cmd.kind;
          in_position <= cur_step.cmd.pos;
          in_run_length <= cur_step.cmd.run;
          in_value <= cur_step.cmd.value;
          n_issued++;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: one long hold-off, otherwise stall modes that change over time.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        out_stall <= 1'b1;
      end else if (cmds_done && due_replies.size() == 0) begin
        out_stall <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(10, 60);
        end
        rx_mode_left--;
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        $error("unexpected transfer: read_data %0h count_now %0d status %0d",
               out_read_data, out_count_now, out_status);
        err_count++;
      end else begin
        want = due_replies.pop_front();
        n_checked++;
        status_hits[want.status]++;
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_read_data);
          err_count++;
        end
        if (out_count_now !== want.count) begin
          $error("count_now: expected %0d, got %0d", want.count, out_count_now);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_row(KIND_POP,    0,  0,  32'h0,         1, 1, 32'h0,         0,  ST_EMPTY);
    add_row(KIND_READ,   0,  0,  32'h0,         1, 1, 32'h0,         0,  ST_RANGE);
    add_row(KIND_WRITE,  0,  0,  32'hDEAD_BEEF, 1, 1, 32'h0,         0,  ST_RANGE);
    add_row(KIND_ERASE,  0,  0,  32'h0,         1, 1, 32'h0,         0,  ST_OK);
    add_row(KIND_ERASE,  0,  1,  32'h0,         1, 1, 32'h0,         0,  ST_RANGE);
    add_row(KIND_INSERT, 1,  0,  32'h1111_1111, 1, 1, 32'h0,         0,  ST_RANGE);
    add_row(KIND_INSERT, 0,  0,  32'h7FFF_FFFF, 1, 1, 32'h0,         1,  ST_OK);
    add_row(KIND_PUSH,   0,  0,  32'h8000_0000, 1, 1, 32'h0,         2,  ST_OK);
    add_row(KIND_READ,   0,  0,  32'h0,         1, 1, 32'h7FFF_FFFF, 2,  ST_OK);
    add_row(KIND_READ,   1,  0,  32'h0,         1, 1, 32'h8000_0000, 2,  ST_OK);
    add_row(KIND_UNUSED, 31, 31, 32'hFFFF_FFFF, 1, 1, 32'h0,         2,  ST_OK);
    add_row(KIND_PUSH,   0,  0,  32'h0000_FFFF, 13, 0, 32'h0,        0,  ST_OK);
    add_row(KIND_INSERT, 15, 0,  32'h1234_5678, 1, 1, 32'h0,         16, ST_OK);
    add_row(KIND_PUSH,   0,  0,  32'h2222_2222, 1, 1, 32'h0,         16, ST_FULL);
    add_row(KIND_INSERT, 20, 0,  32'h3333_3333, 1, 1, 32'h0,         16, ST_FULL);
    add_row(KIND_READ,   31, 0,  32'h0,         1, 1, 32'h0,         16, ST_RANGE);
    add_row(KIND_WRITE,  15, 0,  32'hA5A5_A5A5, 1, 1, 32'h0,         16, ST_OK);
    add_row(KIND_READ,   15, 0,  32'h0,         1, 1, 32'hA5A5_A5A5, 16, ST_OK);
    add_row(KIND_ERASE,  1,  16, 32'h0,         1, 1, 32'h0,         16, ST_RANGE);
    add_row(KIND_ERASE,  16, 16, 32'h0,         1, 1, 32'h0,         16, ST_RANGE);
    add_row(KIND_ERASE,  2,  3,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
    add_row(KIND_INSERT, 1,  0,  32'h5555_AAAA, 1, 0, 32'h0,         0,  ST_OK);
    add_row(KIND_READ,   1,  0,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
    add_row(KIND_WRITE,  0,  0,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
    add_row(KIND_POP,    0,  0,  32'h0,         1, 0, 32'h0,         0,  ST_OK);
    add_row(KIND_ERASE,  0,  13, 32'h0,         1, 1, 32'h0,         0,  ST_OK);
    add_row(KIND_PUSH,   0,  0,  32'h0000_0001, 1, 1, 32'h0,         1,  ST_OK);
    add_row(KIND_CLEAR,  0,  0,  32'h0,         1, 1, 32'h0,         0,  ST_OK);
    add_row(KIND_POP,    0,  0,  32'h0,         1, 1, 32'h0,         0,  ST_EMPTY);
    n_directed = plan_q.size();
    n_total = n_directed + RANDOM_ITEMS;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (!(cmds_done && due_replies.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d from the edge-case table), checked %0d responses.",
             n_sent, n_directed, n_checked);
    $display("Responses ok/full/empty/range: %0d/%0d/%0d/%0d, deepest fill %0d of %0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_RANGE], max_fill, DEPTH);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
